[rtl/tbp_pkg.sv]
// Shared types, constants and counter helpers for the tournament branch predictor.
// Used by tbp_table, tbp_train and tournament_branch_predictor; depends on nothing.

package tbp_pkg;

  // Default size of the predictor: the gshare table has 2^(BUDGET_LOG-1) entries.
  localparam int BUDGET_LOG_DEFAULT = 13;

  typedef logic [1:0] ctr_t;

  localparam ctr_t CTR_SAT_LOW    = 2'd0;
  localparam ctr_t CTR_TAKEN_WEAK = 2'd2;
  localparam ctr_t CTR_SAT_HIGH   = 2'd3;

  // Counter values read for one branch.
  typedef struct packed {
    ctr_t glob;
    ctr_t loc;
    ctr_t sel;
  } tbp_ctrs_t;

  // Prediction and training outcome for one branch.
  typedef struct packed {
    logic pred;
    logic ok;
    logic use_g;
    ctr_t glob_next;
    ctr_t loc_next;
    ctr_t sel_next;
  } tbp_train_t;

  function automatic ctr_t sat_move(ctr_t v, logic up);
    ctr_t r;
    if (up) begin
      r = (v == CTR_SAT_HIGH) ? CTR_SAT_HIGH : v + 2'd1;
    end else begin
      r = (v == CTR_SAT_LOW) ? CTR_SAT_LOW : v - 2'd1;
    end
    return r;
  endfunction

endpackage

[rtl/tbp_table.sv]
// Table of 2-bit saturating counters with one write port and one registered read port.
// A read that meets a write to the same entry in the same cycle returns the new value.
// Depends on tbp_pkg.

module tbp_table #(
  parameter int ADDR_BITS = 11
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output tbp_pkg::ctr_t        rd_data,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  tbp_pkg::ctr_t        wr_data
);

  localparam int DEPTH = 1 << ADDR_BITS;

  tbp_pkg::ctr_t mem [DEPTH];
  tbp_pkg::ctr_t mem_q;
  tbp_pkg::ctr_t fwd_data;
  logic          fwd_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // The array read sees the old entry when a write lands on the same edge, so the
  // written value is captured alongside and chosen instead.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q    <= mem[rd_addr];
      fwd_hit  <= wr_en && (wr_addr == rd_addr);
      fwd_data <= wr_data;
    end
  end

  assign rd_data = fwd_hit ? fwd_data : mem_q;

endmodule

[rtl/tbp_train.sv]
// Prediction and counter training for one conditional branch.
// Purely combinational; depends on tbp_pkg.

module tbp_train (
  input  tbp_pkg::tbp_ctrs_t ctrs,
  input  logic               actual,
  output tbp_pkg::tbp_train_t res
);

  logic gpred;
  logic bpred;

  always_comb begin
    gpred         = ctrs.glob >= tbp_pkg::CTR_TAKEN_WEAK;
    bpred         = ctrs.loc >= tbp_pkg::CTR_TAKEN_WEAK;
    res.use_g     = ctrs.sel >= tbp_pkg::CTR_TAKEN_WEAK;
    res.pred      = res.use_g ? gpred : bpred;
    res.ok        = res.pred == actual;
    res.glob_next = tbp_pkg::sat_move(ctrs.glob, actual);
    res.loc_next  = tbp_pkg::sat_move(ctrs.loc, actual);
    // The chooser only learns when the two components disagree.
    if (gpred != bpred) begin
      res.sel_next = tbp_pkg::sat_move(ctrs.sel, gpred == actual);
    end else begin
      res.sel_next = ctrs.sel;
    end
  end

endmodule

[rtl/tournament_branch_predictor.sv]
// Top level of the tournament (gshare plus bimodal) branch predictor.
// Depends on tbp_pkg, tbp_table and tbp_train.
//
//   channel  direction  handshake                    payload
//   branch   in         branch_valid / branch_ready  branch_pc, actual_taken, is_conditional
//   result   out        result_valid / result_ready  predicted_taken, prediction_correct,
//                                                    chose_global, mispredict_total
//
// One branch is taken per cycle unless a stalled result holds the input; a result is
// offered once its branch has left the stage. The counter tables read on the transfer
// edge and are written back as the branch leaves the stage.
// After reset a clearing pass walks all 2^(BUDGET_LOG-1) gshare indices (4096 by default)
// and zeroes the tables; branch_ready stays low throughout.
// A stalled result holds the stage behind it, which then holds the input.
// Records that are not conditional are taken and dropped without a result.

module tournament_branch_predictor #(
  parameter int BUDGET_LOG = tbp_pkg::BUDGET_LOG_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        branch_valid,
  output logic        branch_ready,
  input  logic [31:0] branch_pc,
  input  logic        actual_taken,
  input  logic        is_conditional,
  output logic        result_valid,
  input  logic        result_ready,
  output logic        predicted_taken,
  output logic        prediction_correct,
  output logic        chose_global,
  output logic [31:0] mispredict_total
);

  localparam int GS_BITS = BUDGET_LOG - 1;
  localparam int BM_BITS = BUDGET_LOG - 2;

  logic                clearing;
  logic [GS_BITS-1:0]  clr_idx;
  logic [GS_BITS-1:0]  hist;
  logic                s1_valid;
  logic [GS_BITS-1:0]  s1_gi;
  logic [BM_BITS-1:0]  s1_bi;
  logic                s1_actual;
  logic                s1_adv;
  logic                rd_en;
  logic [GS_BITS-1:0]  gi;
  logic [BM_BITS-1:0]  bi;
  logic                wr_en;
  logic [GS_BITS-1:0]  wr_gi;
  logic [BM_BITS-1:0]  wr_bi;
  tbp_pkg::ctr_t       wr_glob;
  tbp_pkg::ctr_t       wr_loc;
  tbp_pkg::ctr_t       wr_sel;
  tbp_pkg::tbp_ctrs_t  ctrs;
  tbp_pkg::tbp_train_t trn;
  logic [31:0]         miss_count;
  logic [31:0]         miss_next;

  assign s1_adv       = s1_valid && (!result_valid || result_ready);
  assign branch_ready = !clearing && (!s1_valid || s1_adv);
  assign rd_en        = branch_valid && branch_ready && is_conditional;
  assign gi           = branch_pc[GS_BITS-1:0] ^ hist;
  assign bi           = branch_pc[BM_BITS-1:0];

  // Clearing pass after reset, one entry of every table per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + GS_BITS'(1);
      if (clr_idx == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  // History moves on at the transfer of a conditional branch, so the next branch indexes with it at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      hist <= '0;
    end else if (rd_en) begin
      hist <= {hist[GS_BITS-2:0], actual_taken};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (branch_ready) begin
      s1_valid <= rd_en;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_gi     <= gi;
      s1_bi     <= bi;
      s1_actual <= actual_taken;
    end
  end

  always_comb begin
    if (clearing) begin
      wr_en   = 1'b1;
      wr_gi   = clr_idx;
      wr_bi   = clr_idx[BM_BITS-1:0];
      wr_glob = tbp_pkg::CTR_SAT_LOW;
      wr_loc  = tbp_pkg::CTR_SAT_LOW;
      wr_sel  = tbp_pkg::CTR_SAT_LOW;
    end else begin
      wr_en   = s1_adv;
      wr_gi   = s1_gi;
      wr_bi   = s1_bi;
      wr_glob = trn.glob_next;
      wr_loc  = trn.loc_next;
      wr_sel  = trn.sel_next;
    end
  end

  tbp_table #(.ADDR_BITS(GS_BITS)) u_glob (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (gi),
    .rd_data (ctrs.glob),
    .wr_en   (wr_en),
    .wr_addr (wr_gi),
    .wr_data (wr_glob)
  );

  tbp_table #(.ADDR_BITS(BM_BITS)) u_loc (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (bi),
    .rd_data (ctrs.loc),
    .wr_en   (wr_en),
    .wr_addr (wr_bi),
    .wr_data (wr_loc)
  );

  tbp_table #(.ADDR_BITS(BM_BITS)) u_sel (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (bi),
    .rd_data (ctrs.sel),
    .wr_en   (wr_en),
    .wr_addr (wr_bi),
    .wr_data (wr_sel)
  );

  tbp_train u_train (
    .ctrs   (ctrs),
    .actual (s1_actual),
    .res    (trn)
  );

  assign miss_next = miss_count + {31'd0, !trn.ok};

  always_ff @(posedge clk) begin
    if (rst) begin
      miss_count <= '0;
    end else if (s1_adv) begin
      miss_count <= miss_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      predicted_taken    <= trn.pred;
      prediction_correct <= trn.ok;
      chose_global       <= trn.use_g;
      mispredict_total   <= miss_next;
    end
  end

`ifndef SYNTH
  a_no_transfer_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !branch_ready)
    else $error("branch taken during the clearing pass");

  a_cond_enters_stage: assert property (@(posedge clk) disable iff (rst)
    rd_en |=> s1_valid)
    else $error("conditional branch lost after transfer");

  a_stage_to_result: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> result_valid && (mispredict_total == miss_count))
    else $error("stage advanced without a matching result");

  a_miss_count_step: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> miss_count == $past(miss_count) + {31'd0, !prediction_correct})
    else $error("mispredict count out of step with the result");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_gi) && $stable(s1_bi))
    else $error("stalled branch changed in the stage");
`endif

endmodule
